@@ src/prf_pkg.sv @@
// shared types, constants and codes of the position restraint force block
// no dependencies; imported by every module of the block

package prf_pkg;

	localparam int NUM_STATES      = 4;
	localparam int ATOM_INDEX_BITS = 16;
	localparam int LAMBDA_REGS     = 4;
	localparam int AXES            = 3;
	localparam int QUEUE_DEPTH     = 2;

	localparam int N_USE_MAX   = (NUM_STATES < LAMBDA_REGS) ? NUM_STATES : LAMBDA_REGS;
	localparam int STATE_IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int LAMBDA_IDX_W = (LAMBDA_REGS > 1) ? $clog2(LAMBDA_REGS) : 1;
	localparam int AXIS_W      = $clog2(AXES);

	localparam logic [15:0] ATOM_MASK = (ATOM_INDEX_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << ATOM_INDEX_BITS) - 32'd1);

	localparam logic [15:0] LAMBDA_ONE = 16'd32768;
	localparam logic [63:0] SAT64      = 64'h7FFF_FFFF_FFFF_FFFF;

	// register indexes of the configuration port
	localparam logic [2:0] CFG_ACTIVE  = 3'd0;
	localparam logic [2:0] CFG_LAMBDA0 = 3'd1;

	typedef enum logic [1:0] {
		KIND_FORCE = 2'd0,
		KIND_STATE = 2'd1,
		KIND_PLAIN = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ABS,
		BK_RUN,
		BK_UPD,
		BK_EMIT_F,
		BK_EMIT_S,
		BK_EMIT_P
	} bk_state_t;

	// one classified restraint as it waits between front and back
	typedef struct packed {
		logic [15:0]               atom;
		logic [15:0]               lam;
		logic [NUM_STATES-1:0]     st_mask;
		logic                      plain;
		logic                      last;
		logic [AXES-1:0][32:0]     d;
		logic [AXES-1:0][23:0]     k;
	} prf_item_t;

endpackage

@@ src/prf_front.sv @@
// front part: configuration registers, item acceptance and classification
// depends on prf_pkg; pushes classified items into prf_queue

module prf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         atom_index,
	input  logic [2:0]          state_sel,
	input  logic signed [31:0]  atom_x,
	input  logic signed [31:0]  atom_y,
	input  logic signed [31:0]  atom_z,
	input  logic signed [31:0]  ref_x,
	input  logic signed [31:0]  ref_y,
	input  logic signed [31:0]  ref_z,
	input  logic [23:0]         k_x,
	input  logic [23:0]         k_y,
	input  logic [23:0]         k_z,
	input  logic                last_restraint,
	input  logic                q_full,
	output logic                q_push,
	output prf_pkg::prf_item_t  q_item,
	output logic [2:0]          n_use
);
	import prf_pkg::*;

	logic [2:0]                        active_q;
	logic [LAMBDA_REGS-1:0][15:0]      lambda_q;
	logic [2:0]                        lam_off;
	logic                              sel_ok;
	logic [15:0]                       lam;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < LAMBDA_REGS; i++) begin
				lambda_q[i] <= (i == 0) ? LAMBDA_ONE : 16'd0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_ACTIVE) begin
				active_q <= cfg_data[2:0];
			end else if (cfg_index >= CFG_LAMBDA0 &&
					cfg_index < CFG_LAMBDA0 + 3'(LAMBDA_REGS)) begin
				lambda_q[LAMBDA_IDX_W'(cfg_index - CFG_LAMBDA0)] <= cfg_data;
			end
		end
	end

	// states in use: the count clamped to the accumulators and lambda registers
	assign n_use = (active_q > 3'(N_USE_MAX)) ? 3'(N_USE_MAX) : active_q;

	assign lam_off = state_sel - 3'd1;
	assign sel_ok  = (state_sel == 3'd0) || (state_sel <= n_use);

	always_comb begin
		if (state_sel == 3'd0) begin
			lam = LAMBDA_ONE;
		end else if (sel_ok) begin
			lam = lambda_q[LAMBDA_IDX_W'(lam_off)];
		end else begin
			lam = 16'd0;
		end
	end

	always_comb begin
		q_item.atom  = atom_index & ATOM_MASK;
		q_item.lam   = lam;
		q_item.last  = last_restraint;
		q_item.plain = (state_sel == 3'd0) && (n_use == 3'd0);
		for (int i = 0; i < NUM_STATES; i++) begin
			if (state_sel == 3'd0) begin
				q_item.st_mask[i] = 3'(i) < n_use;
			end else begin
				q_item.st_mask[i] = sel_ok && (lam_off == 3'(i));
			end
		end
		q_item.d[0] = 33'(atom_x) - 33'(ref_x);
		q_item.d[1] = 33'(atom_y) - 33'(ref_y);
		q_item.d[2] = 33'(atom_z) - 33'(ref_z);
		q_item.k[0] = k_x;
		q_item.k[1] = k_y;
		q_item.k[2] = k_z;
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

@@ src/prf_queue.sv @@
// short queue of classified items between the front and back parts
// depends on prf_pkg for the item type and depth

module prf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  prf_pkg::prf_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output prf_pkg::prf_item_t  head
);
	import prf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	prf_item_t         ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/prf_back.sv @@
// back part: per-axis multiply pipeline, energy accumulators and result register
// depends on prf_pkg; takes items from prf_queue

module prf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  prf_pkg::prf_item_t  q_item,
	output logic                q_pop,
	input  logic [2:0]          n_use,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [15:0]         out_atom,
	output logic signed [47:0]  force_x,
	output logic signed [47:0]  force_y,
	output logic signed [47:0]  force_z,
	output logic [1:0]          energy_state,
	output logic signed [63:0]  energy_value,
	output logic                last_result
);
	import prf_pkg::*;

	localparam logic [2:0] RUN_LAST = 3'(AXES + 3);

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > 65'(SAT64)) ? SAT64 : s[63:0];
	endfunction

	bk_state_t state_q, state_d;
	prf_item_t item_q;

	logic [AXES-1:0][31:0]          m_q;
	logic [AXES-1:0]                neg_q;
	logic [2:0]                     run_cnt_q;
	logic [STATE_IDX_W-1:0]         st_idx_q;
	logic [AXES-1:0][47:0]          force_q;
	logic [63:0]                    e_q;
	logic [NUM_STATES-1:0][63:0]    st_e_q;
	logic [63:0]                    plain_q;

	// control decisions of the current cycle
	logic out_free, run_last, st_last;
	logic load_item, do_abs, feed, do_upd, emit_f, emit_s, emit_p;

	// axis pipeline
	logic                v_s1, v_s2, v_s3, v_s4;
	logic [AXIS_W-1:0]   ax_s1, ax_s2, ax_s3, ax_s4;
	logic                neg_s1, neg_s2, neg_s3;
	logic [23:0]         k_s1;
	logic [55:0]         p_s1;
	logic [63:0]         sq_s1;
	logic [48:0]         hi_s2;
	logic [39:0]         lo_s2;
	logic [41:0]         kl_s2;
	logic [55:0]         khl_s2;
	logic [38:0]         khh_s2;
	logic [49:0]         q_s3;
	logic [70:0]         kh_s3;
	logic [24:0]         tt_s3;
	logic [47:0]         force_s4;
	logic [63:0]         term_s4;

	logic [AXIS_W-1:0]   ax_in;
	logic [47:0]         force_n;
	logic [63:0]         term_n;
	logic [63:0]         kh_sum;

	// result register
	logic                out_valid_q;
	kind_t               kind_q;
	logic [15:0]         atom_q;
	logic [AXES-1:0][47:0] fo_q;
	logic [1:0]          estate_q;
	logic [63:0]         evalue_q;
	logic                last_q;

	assign out_free = !out_valid_q || !out_stall;
	assign run_last = run_cnt_q == RUN_LAST;
	assign st_last  = 3'(st_idx_q) == (n_use - 3'd1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) state_d = BK_ABS;
			end
			BK_ABS: state_d = BK_RUN;
			BK_RUN: begin
				if (run_last) state_d = BK_UPD;
			end
			BK_UPD: state_d = BK_EMIT_F;
			BK_EMIT_F: begin
				if (out_free) begin
					if (!item_q.last) begin
						state_d = BK_IDLE;
					end else if (n_use != 3'd0) begin
						state_d = BK_EMIT_S;
					end else begin
						state_d = BK_EMIT_P;
					end
				end
			end
			BK_EMIT_S: begin
				if (out_free && st_last) state_d = BK_EMIT_P;
			end
			BK_EMIT_P: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		load_item = 1'b0;
		do_abs    = 1'b0;
		feed      = 1'b0;
		do_upd    = 1'b0;
		emit_f    = 1'b0;
		emit_s    = 1'b0;
		emit_p    = 1'b0;
		unique case (state_q)
			BK_IDLE:   load_item = !q_empty;
			BK_ABS:    do_abs = 1'b1;
			BK_RUN:    feed = run_cnt_q < 3'(AXES);
			BK_UPD:    do_upd = 1'b1;
			BK_EMIT_F: emit_f = out_free;
			BK_EMIT_S: emit_s = out_free;
			BK_EMIT_P: emit_p = out_free;
			default: ;
		endcase
	end

	assign q_pop = load_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			run_cnt_q <= '0;
			st_idx_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= feed;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			if (do_abs) begin
				run_cnt_q <= '0;
			end else if (state_q == BK_RUN) begin
				run_cnt_q <= run_cnt_q + 3'd1;
			end
			if (emit_f) begin
				st_idx_q <= '0;
			end else if (emit_s) begin
				st_idx_q <= st_idx_q + 1'b1;
			end
		end
	end

	// item capture and displacement magnitudes
	always_ff @(posedge clk) begin
		if (load_item) begin
			item_q <= q_item;
		end
		if (do_abs) begin
			for (int a = 0; a < AXES; a++) begin
				neg_q[a] <= item_q.d[a][32];
				m_q[a]   <= item_q.d[a][32] ? 32'(-item_q.d[a]) : item_q.d[a][31:0];
			end
		end
	end

	assign ax_in = run_cnt_q[AXIS_W-1:0];

	// stage 1: k*|d| and |d|^2
	always_ff @(posedge clk) begin
		ax_s1  <= ax_in;
		neg_s1 <= neg_q[ax_in];
		k_s1   <= item_q.k[ax_in];
		p_s1   <= 56'(item_q.k[ax_in]) * 56'(m_q[ax_in]);
		sq_s1  <= 64'(m_q[ax_in]) * 64'(m_q[ax_in]);
	end

	// stage 2: weight by lambda and scale the squared term by k, split in parts
	always_ff @(posedge clk) begin
		ax_s2  <= ax_s1;
		neg_s2 <= neg_s1;
		hi_s2  <= 49'(p_s1[55:23]) * 49'(item_q.lam);
		lo_s2  <= 40'(p_s1[22:0]) * 40'(item_q.lam) + 40'h40_0000;
		kl_s2  <= 42'(k_s1) * 42'(sq_s1[16:0]) + 42'h1_0000;
		khl_s2 <= 56'(k_s1) * 56'(sq_s1[48:17]);
		khh_s2 <= 39'(k_s1) * 39'(sq_s1[63:49]);
	end

	// stage 3: recombine partial products
	always_ff @(posedge clk) begin
		ax_s3  <= ax_s2;
		neg_s3 <= neg_s2;
		q_s3   <= 50'(hi_s2) + 50'(lo_s2[39:23]);
		kh_s3  <= {khh_s2, 32'd0} + 71'(khl_s2);
		tt_s3  <= kl_s2[41:17];
	end

	// stage 4: saturate the force, form the axis energy term
	always_comb begin
		if (neg_s3) begin
			force_n = (q_s3 > 50'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'(-q_s3[47:0]);
		end else begin
			force_n = (q_s3 > 50'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q_s3[47:0];
		end
		kh_sum = {1'b0, kh_s3[62:0]} + 64'(tt_s3);
		if (kh_s3 > 71'(SAT64) || kh_sum > SAT64) begin
			term_n = SAT64;
		end else begin
			term_n = kh_sum;
		end
	end

	always_ff @(posedge clk) begin
		ax_s4    <= ax_s3;
		force_s4 <= force_n;
		term_s4  <= term_n;
	end

	// stage 5: collect forces and the item energy
	always_ff @(posedge clk) begin
		if (do_abs) begin
			e_q <= '0;
		end else if (v_s4) begin
			e_q <= sat_add(e_q, term_s4);
		end
		if (v_s4) begin
			force_q[ax_s4] <= force_s4;
		end
	end

	// energy accumulators, cleared after the plain energy of a last item goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_e_q  <= '0;
			plain_q <= '0;
		end else if (do_upd) begin
			for (int i = 0; i < NUM_STATES; i++) begin
				if (item_q.st_mask[i]) st_e_q[i] <= sat_add(st_e_q[i], e_q);
			end
			if (item_q.plain) plain_q <= sat_add(plain_q, e_q);
		end else if (emit_p) begin
			st_e_q  <= '0;
			plain_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_f || emit_s || emit_p) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_f) begin
			kind_q   <= KIND_FORCE;
			atom_q   <= item_q.atom;
			fo_q     <= force_q;
			estate_q <= 2'd0;
			evalue_q <= '0;
			last_q   <= !item_q.last;
		end else if (emit_s) begin
			kind_q   <= KIND_STATE;
			atom_q   <= '0;
			fo_q     <= '0;
			estate_q <= 2'(st_idx_q);
			evalue_q <= st_e_q[st_idx_q];
			last_q   <= 1'b0;
		end else if (emit_p) begin
			kind_q   <= KIND_PLAIN;
			atom_q   <= '0;
			fo_q     <= '0;
			estate_q <= 2'd0;
			evalue_q <= plain_q;
			last_q   <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign out_atom     = atom_q;
	assign force_x      = $signed(fo_q[0]);
	assign force_y      = $signed(fo_q[1]);
	assign force_z      = $signed(fo_q[2]);
	assign energy_state = estate_q;
	assign energy_value = $signed(evalue_q);
	assign last_result  = last_q;

endmodule

@@ src/position_restraint_force.sv @@
// harmonic position restraint force unit, top level: front, queue and back part
// sequencing: the back takes one item at a time from the queue and steps through idle, abs,
// run (the axis pipeline) and upd to emit_f, where a stalled output can hold it; an item
// marked last then emits one result per active state plus one for the plain energy
// reset: config to defaults (lambda of state 1 at 1.0), accumulators zero, queue empty
// depends on prf_pkg, prf_front, prf_queue, prf_back

module position_restraint_force (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         atom_index,
	input  logic [2:0]          state_sel,
	input  logic signed [31:0]  atom_x,
	input  logic signed [31:0]  atom_y,
	input  logic signed [31:0]  atom_z,
	input  logic signed [31:0]  ref_x,
	input  logic signed [31:0]  ref_y,
	input  logic signed [31:0]  ref_z,
	input  logic [23:0]         k_x,
	input  logic [23:0]         k_y,
	input  logic [23:0]         k_z,
	input  logic                last_restraint,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [15:0]         out_atom,
	output logic signed [47:0]  force_x,
	output logic signed [47:0]  force_y,
	output logic signed [47:0]  force_z,
	output logic [1:0]          energy_state,
	output logic signed [63:0]  energy_value,
	output logic                last_result
);
	import prf_pkg::*;

	prf_item_t   push_item;
	prf_item_t   head_item;
	logic        q_push, q_pop, q_full, q_empty;
	logic [2:0]  n_use;

	prf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.atom_index     (atom_index),
		.state_sel      (state_sel),
		.atom_x         (atom_x),
		.atom_y         (atom_y),
		.atom_z         (atom_z),
		.ref_x          (ref_x),
		.ref_y          (ref_y),
		.ref_z          (ref_z),
		.k_x            (k_x),
		.k_y            (k_y),
		.k_z            (k_z),
		.last_restraint (last_restraint),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (push_item),
		.n_use          (n_use)
	);

	prf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head_item)
	);

	prf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_item       (head_item),
		.q_pop        (q_pop),
		.n_use        (n_use),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.out_atom     (out_atom),
		.force_x      (force_x),
		.force_y      (force_y),
		.force_z      (force_z),
		.energy_state (energy_state),
		.energy_value (energy_value),
		.last_result  (last_result)
	);

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench of position_restraint_force: directed table, then random phases
// under several register settings, with random idling and one long output hold-off
// depends on prf_pkg and the position_restraint_force rtl

module tb_top;
	import prf_pkg::*;

	localparam int LIMIT      = 200000;
	localparam int PHASE_SIZE = 60;
	localparam int HOLD_LEN   = 300;

	typedef struct packed {
		logic [15:0]       atom;
		logic [2:0]        sel;
		logic [2:0][31:0]  pos;
		logic [2:0][31:0]  anc;
		logic [2:0][23:0]  kc;
		logic              last;
		logic              typed;
		logic [2:0][47:0]  tf;
	} row_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] atom;
		logic [47:0] fx;
		logic [47:0] fy;
		logic [47:0] fz;
		logic [1:0]  est;
		logic [63:0] ev;
		logic        last;
	} out_rec_t;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               cfg_we         = 1'b0;
	logic [2:0]         cfg_index      = '0;
	logic [15:0]        cfg_data       = '0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic [15:0]        atom_index     = '0;
	logic [2:0]         state_sel      = '0;
	logic signed [31:0] atom_x         = '0;
	logic signed [31:0] atom_y         = '0;
	logic signed [31:0] atom_z         = '0;
	logic signed [31:0] ref_x          = '0;
	logic signed [31:0] ref_y          = '0;
	logic signed [31:0] ref_z          = '0;
	logic [23:0]        k_x            = '0;
	logic [23:0]        k_y            = '0;
	logic [23:0]        k_z            = '0;
	logic               last_restraint = 1'b0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic [1:0]         kind;
	logic [15:0]        out_atom;
	logic signed [47:0] force_x;
	logic signed [47:0] force_y;
	logic signed [47:0] force_z;
	logic [1:0]         energy_state;
	logic signed [63:0] energy_value;
	logic               last_result;

	position_restraint_force dut (.*);

	always #1 clk = ~clk;

	// own copy of the block's registers and energy accumulators
	logic [2:0]  act_states = '0;
	logic [15:0] lam_reg [LAMBDA_REGS] = '{LAMBDA_ONE, 16'd0, 16'd0, 16'd0};
	logic [63:0] st_energy [NUM_STATES] = '{default: '0};
	logic [63:0] plain_energy = '0;

	out_rec_t due_q [$];
	out_rec_t got_exp;
	row_t     dir_tab [$];

	int  errors = 0, cycles = 0, n_items = 0, n_forces = 0, n_energies = 0, n_settings = 1;
	bit  idle_on = 1'b1;
	bit  hold_req = 1'b0;
	int  hold_left = 0, burst_left = 0;

	task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
	endtask

	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > SAT64 || s < a) ? SAT64 : s;
	endfunction

	// force along one axis, energy term added to en
	function automatic void axis_term(input logic [31:0] p_in, input logic [31:0] a_in,
			input logic [23:0] kc, input logic [15:0] lam,
			output logic [47:0] frc, inout logic [63:0] en);
		logic [63:0] d, m, p, q, s, h, l, t, k;
		logic        neg;
		k   = 64'(kc);
		d   = {{32{p_in[31]}}, p_in} - {{32{a_in[31]}}, a_in};
		neg = d[63];
		m   = neg ? -d : d;
		p   = k * m;
		q   = (p >> 23) * 64'(lam) + (((p & 64'h7F_FFFF) * 64'(lam) + 64'h40_0000) >> 23);
		if (neg) begin
			if (q > 64'h8000_0000_0000)
				q = 64'h8000_0000_0000;
			q = -q;
		end else if (q > 64'h7FFF_FFFF_FFFF) begin
			q = 64'h7FFF_FFFF_FFFF;
		end
		frc = q[47:0];
		s = m * m;
		h = s >> 17;
		l = s & 64'h1_FFFF;
		t = (k * l + 64'h1_0000) >> 17;
		if (k != 0 && h > SAT64 / k)
			t = SAT64;
		else
			t = sat_sum(k * h, t);
		en = sat_sum(en, t);
	endfunction

	// expected results of one accepted restraint, energy state updated
	task automatic predict_restraint(input row_t r);
		logic [63:0]      en;
		logic [15:0]      lam;
		logic [2:0][47:0] f;
		logic             ok;
		int               n;
		out_rec_t         o;
		n  = (int'(act_states) > N_USE_MAX) ? N_USE_MAX : int'(act_states);
		ok = 1'b1;
		if (r.sel == 0) begin
			lam = LAMBDA_ONE;
		end else if (int'(r.sel) <= n) begin
			lam = lam_reg[r.sel - 1];
		end else begin
			// selector names no state in use: weight zero, energy dropped
			lam = '0;
			ok  = 1'b0;
		end
		en = '0;
		for (int i = 0; i < AXES; i++)
			axis_term(r.pos[i], r.anc[i], r.kc[i], lam, f[i], en);
		o      = '0;
		o.kind = KIND_FORCE;
		o.atom = r.atom & ATOM_MASK;
		o.fx   = r.typed ? r.tf[0] : f[0];
		o.fy   = r.typed ? r.tf[1] : f[1];
		o.fz   = r.typed ? r.tf[2] : f[2];
		o.last = !r.last;
		due_q.push_back(o);
		if (ok) begin
			if (r.sel == 0) begin
				for (int i = 0; i < n; i++)
					st_energy[i] = sat_sum(st_energy[i], en);
				if (n == 0)
					plain_energy = sat_sum(plain_energy, en);
			end else begin
				st_energy[r.sel - 1] = sat_sum(st_energy[r.sel - 1], en);
			end
		end
		if (r.last) begin
			for (int i = 0; i < n; i++) begin
				o      = '0;
				o.kind = KIND_STATE;
				o.est  = 2'(i);
				o.ev   = st_energy[i];
				due_q.push_back(o);
			end
			o      = '0;
			o.kind = KIND_PLAIN;
			o.ev   = plain_energy;
			o.last = 1'b1;
			due_q.push_back(o);
			for (int i = 0; i < NUM_STATES; i++)
				st_energy[i] = '0;
			plain_energy = '0;
		end
	endtask

	function automatic row_t mk(input logic [15:0] atom, input logic [2:0] sel,
			input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
			input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
			input logic [23:0] kx, input logic [23:0] ky, input logic [23:0] kz,
			input logic last, input logic typed,
			input logic [47:0] fx, input logic [47:0] fy, input logic [47:0] fz);
		row_t r;
		r.atom  = atom;
		r.sel   = sel;
		r.pos   = {az, ay, ax};
		r.anc   = {bz, by, bx};
		r.kc    = {kz, ky, kx};
		r.last  = last;
		r.typed = typed;
		r.tf    = {fz, fy, fx};
		return r;
	endfunction

	function automatic row_t rand_row(input int n_use);
		row_t r;
		int   pick;
		r      = '0;
		r.atom = 16'($urandom);
		pick   = $urandom_range(0, 9);
		if (pick < 3)
			r.sel = '0;
		else if (pick < 8 && n_use > 0)
			r.sel = 3'($urandom_range(1, n_use));
		else
			r.sel = 3'($urandom_range(0, 7));
		for (int i = 0; i < AXES; i++) begin
			r.anc[i] = $urandom;
			case ($urandom_range(0, 3))
				0: begin
					r.pos[i] = $urandom;
					r.kc[i]  = 24'($urandom);
				end
				3: begin
					r.pos[i] = r.anc[i];
					r.kc[i]  = 24'($urandom);
				end
				default: begin
					// near the anchor, moderate spring: energy stays out of saturation
					r.pos[i] = r.anc[i] + 32'($urandom_range(0, 131072)) - 32'd65536;
					r.kc[i]  = 24'($urandom_range(0, 65535));
				end
			endcase
		end
		r.last = ($urandom_range(0, 7) == 0);
		return r;
	endfunction

	task automatic put_restraint(input row_t r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		atom_index     <= r.atom;
		state_sel      <= r.sel;
		atom_x         <= r.pos[0];
		atom_y         <= r.pos[1];
		atom_z         <= r.pos[2];
		ref_x          <= r.anc[0];
		ref_y          <= r.anc[1];
		ref_z          <= r.anc[2];
		k_x            <= r.kc[0];
		k_y            <= r.kc[1];
		k_z            <= r.kc[2];
		last_restraint <= r.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_restraint(r);
		n_items++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == CFG_ACTIVE)
			act_states = data[2:0];
		else if (idx >= CFG_LAMBDA0 && int'(idx) < int'(CFG_LAMBDA0) + LAMBDA_REGS)
			lam_reg[idx - CFG_LAMBDA0] = data;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// let every pending result out, then the back part settle
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic run_phase(input bit hold);
		row_t r;
		int   n_use;
		n_settings++;
		n_use = (int'(act_states) > N_USE_MAX) ? N_USE_MAX : int'(act_states);
		if (hold)
			hold_req = 1'b1;
		for (int i = 0; i < PHASE_SIZE; i++) begin
			r = rand_row(n_use);
			if (i == PHASE_SIZE - 1)
				r.last = 1'b1;
			put_restraint(r);
		end
		drain(16);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, due_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			burst_left = $urandom_range(1, 7) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_q.size() == 0) begin
				flag("result with nothing pending, kind", 64'(kind), '0);
			end else begin
				got_exp = due_q.pop_front();
				if (kind != got_exp.kind)
					flag("kind", 64'(kind), 64'(got_exp.kind));
				if (out_atom != got_exp.atom)
					flag("out_atom", 64'(out_atom), 64'(got_exp.atom));
				if (force_x != got_exp.fx)
					flag("force_x", 64'(force_x), 64'(got_exp.fx));
				if (force_y != got_exp.fy)
					flag("force_y", 64'(force_y), 64'(got_exp.fy));
				if (force_z != got_exp.fz)
					flag("force_z", 64'(force_z), 64'(got_exp.fz));
				if (energy_state != got_exp.est)
					flag("energy_state", 64'(energy_state), 64'(got_exp.est));
				if (energy_value != got_exp.ev)
					flag("energy_value", energy_value, got_exp.ev);
				if (last_result != got_exp.last)
					flag("last_result", 64'(last_result), 64'(got_exp.last));
				if (got_exp.kind == KIND_FORCE)
					n_forces++;
				else
					n_energies++;
			end
		end
	end

	localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
	localparam logic [31:0] PMIN = 32'h8000_0000;
	localparam logic [23:0] KMAX = 24'hFF_FFFF;
	localparam logic [47:0] FMAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] FMIN = 48'h8000_0000_0000;
	localparam logic [47:0] FONE = 48'd4096;

	initial begin
		// reset config: no states active, so only selector 0 carries weight
		dir_tab.push_back(mk(16'h0000, 3'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'h0001, 3'd0, 32'd4096, 0, 0, 0, 32'd4096, 0,
			24'd256, 24'd256, 24'd256, 0, 1, FONE, -FONE, 0));
		// half-lsb ties round away from zero
		dir_tab.push_back(mk(16'h0002, 3'd0, 32'd128, -32'sd128, 32'd127, 0, 0, 0,
			24'd1, 24'd1, 24'd1, 0, 1, 48'd1, -48'sd1, 0));
		// widest displacement, stiffest spring: force and energy saturate
		dir_tab.push_back(mk(16'hFFFF, 3'd0, PMAX, PMIN, PMAX, PMIN, PMAX, PMAX,
			KMAX, KMAX, KMAX, 0, 1, FMAX, FMIN, 0));
		dir_tab.push_back(mk(16'h8000, 3'd0, PMAX, PMIN, PMIN, PMIN, PMAX, PMIN,
			KMAX, KMAX, KMAX, 1, 1, FMAX, FMIN, 0));
		// selector with no state in use: zero force, energy dropped
		dir_tab.push_back(mk(16'h5555, 3'd1, 32'd4096, PMIN, 0, 0, 0, 0,
			24'd256, 24'd256, 24'd256, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'hAAAA, 3'd4, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN,
			KMAX, KMAX, KMAX, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'h0F0F, 3'd5, 32'd100, 0, 0, 0, 0, 0, KMAX, 0, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'hF0F0, 3'd6, 0, 32'd100, 0, 0, 0, 0, 0, KMAX, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'h1234, 3'd7, 0, 0, 32'd100, 0, 0, 0, 0, 0, KMAX, 1, 1, 0, 0, 0));
		// zero spring, large displacement
		dir_tab.push_back(mk(16'h00FF, 3'd0, PMAX, PMIN, 32'd12345, PMIN, PMAX, 0,
			0, 0, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'hFF00, 3'd0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_1234,
			32'h5555_0000, 32'hAAAA_FFFF, 32'h0000_0000, 24'hAA_AAAA, 24'h55_5555,
			24'h00_0100, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(16'h7FFF, 3'd0, 32'd40000, -32'sd40000, 32'd1, 0, 0, 0,
			24'd65535, 24'd300, 24'd1, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(16'hC3C3, 3'd0, 32'd3, -32'sd7, 32'd256, 32'd1, 32'd1, 32'd1,
			24'd777, 24'd12345, 24'h80_0000, 1, 0, 0, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			put_restraint(dir_tab[i]);
		drain(16);

		// all states, lambda extremes including above 1.0
		write_reg(CFG_ACTIVE, 16'd4);
		write_reg(CFG_LAMBDA0, LAMBDA_ONE);
		write_reg(CFG_LAMBDA0 + 3'd1, 16'd0);
		write_reg(CFG_LAMBDA0 + 3'd2, 16'hFFFF);
		write_reg(CFG_LAMBDA0 + 3'd3, 16'($urandom));
		run_phase(1'b0);

		// count above the states available, with junk above the field; long output hold-off
		write_reg(CFG_ACTIVE, {13'($urandom), 3'd7});
		for (int i = 0; i < LAMBDA_REGS; i++)
			write_reg(CFG_LAMBDA0 + 3'(i), 16'($urandom));
		run_phase(1'b1);

		// one state at zero weight; writes to unused indexes must do nothing
		write_reg(CFG_ACTIVE, 16'd1);
		write_reg(CFG_LAMBDA0, 16'd0);
		for (int i = int'(CFG_LAMBDA0) + LAMBDA_REGS; i < 8; i++)
			write_reg(3'(i), 16'($urandom));
		run_phase(1'b0);

		write_reg(CFG_ACTIVE, 16'($urandom_range(2, 3)));
		for (int i = 0; i < LAMBDA_REGS; i++)
			write_reg(CFG_LAMBDA0 + 3'(i), 16'($urandom_range(0, 32768)));
		run_phase(1'b0);

		// back to plain energy only, both sides at full rate
		write_reg(CFG_ACTIVE, {13'($urandom), 3'd0});
		idle_on = 1'b0;
		run_phase(1'b0);

		drain(24);
		$display("%0d restraints over %0d register settings, directed extremes then random frames",
			n_items, n_settings);
		$display("%0d force and %0d energy results checked, %0d mismatches",
			n_forces, n_energies, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/prf_pkg.sv
src/prf_front.sv
src/prf_queue.sv
src/prf_back.sv
src/position_restraint_force.sv
dv/tb_top.sv
